>>> rtl/b32d_pkg.sv
// Shared types, constants and the group-to-bytes packing for the base32 decoder.
`timescale 1ns / 1ps

package b32d_pkg;

	localparam logic [7:0]  PAD_CHAR     = 8'h3d;   // '='
	localparam logic [7:0]  UPPER_FIRST  = 8'h41;   // 'A'
	localparam logic [7:0]  UPPER_LAST   = 8'h5a;   // 'Z'
	localparam logic [7:0]  LOWER_FIRST  = 8'h61;   // 'a'
	localparam logic [7:0]  LOWER_LAST   = 8'h7a;   // 'z'
	localparam logic [7:0]  DIGIT_FIRST  = 8'h32;   // '2'
	localparam logic [7:0]  DIGIT_LAST   = 8'h37;   // '7'
	// '2' minus this offset lands on 26
	localparam logic [7:0]  DIGIT_OFFSET = 8'h18;

	localparam logic [15:0] LIMIT_RESET  = 16'hffff;
	localparam int          GROUP_SYMS   = 8;
	localparam int          GROUP_BYTES  = 5;
	localparam int          QUEUE_DEPTH  = 4;
	localparam int          QPTR_W       = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		REG_OUTPUT_LIMIT = 1'b0
	} reg_addr_t;

	// One queued transaction: everything the back end needs to emit its results
	typedef struct packed {
		logic [GROUP_BYTES-1:0][7:0] bytes;
		logic [2:0]                  nbytes;  // decoded bytes to emit, 0..5
		logic [15:0]                 count;   // byte count before this item's bytes
		logic                        bad;     // illegal character
		logic                        last;    // last character of the string
	} job_t;

	typedef logic [GROUP_SYMS-1:0][4:0] group_t;
	typedef logic [GROUP_BYTES-1:0][7:0] bytes_t;

	// Repack eight 5-bit symbols into five bytes, first symbol in the top bits
	function automatic bytes_t pack_group(input group_t s);
		bytes_t b;
		b[0] = {s[0], s[1][4:2]};
		b[1] = {s[1][1:0], s[2], s[3][4]};
		b[2] = {s[3][3:0], s[4][4:1]};
		b[3] = {s[4][0], s[5], s[6][4:3]};
		b[4] = {s[6][2:0], s[7]};
		return b;
	endfunction

endpackage

>>> rtl/b32d_front.sv
// Front end: accept characters, decode symbols, track the string state, build jobs.
`timescale 1ns / 1ps

module b32d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] in_char
	input  logic              s_tlast,   // end_of_string
	input  logic [15:0]       limit,
	input  logic              q_full,
	output logic              push,
	output b32d_pkg::job_t    push_job
);
	import b32d_pkg::*;

	group_t      group_q, group_n;
	logic [2:0]  index_q;
	logic        pad_q;
	logic [15:0] count_q;
	logic        drop_q;

	logic        accept, is_pad, is_upper, is_lower, is_digit, legal;
	logic        bad, flush, pad_n;
	logic [7:0]  sym_wide;
	logic [4:0]  sym;
	logic [15:0] room, count_n;
	logic [2:0]  nbytes;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		is_pad   = s_tdata == PAD_CHAR;
		is_upper = s_tdata >= UPPER_FIRST && s_tdata <= UPPER_LAST;
		is_lower = s_tdata >= LOWER_FIRST && s_tdata <= LOWER_LAST;
		is_digit = s_tdata >= DIGIT_FIRST && s_tdata <= DIGIT_LAST;
		legal    = is_pad || is_upper || is_lower || is_digit;

		if (is_upper)      sym_wide = s_tdata - UPPER_FIRST;
		else if (is_lower) sym_wide = s_tdata - LOWER_FIRST;
		else if (is_digit) sym_wide = s_tdata - DIGIT_OFFSET;
		else               sym_wide = 8'd0;
		sym = sym_wide[4:0];

		bad   = !drop_q && !legal;
		pad_n = pad_q || is_pad;

		group_n          = group_q;
		group_n[index_q] = sym;

		flush = !drop_q && legal && (index_q == 3'(GROUP_SYMS - 1) || pad_n || s_tlast);

		room = (count_q >= limit) ? 16'd0 : limit - count_q;
		if (!flush)                           nbytes = 3'd0;
		else if (room >= 16'(GROUP_BYTES))    nbytes = 3'(GROUP_BYTES);
		else                                  nbytes = room[2:0];
		count_n = count_q + 16'(nbytes);

		push_job.bytes  = pack_group(group_n);
		push_job.nbytes = nbytes;
		push_job.count  = count_q;
		push_job.bad    = bad;
		push_job.last   = s_tlast;
		push = accept && (bad || nbytes != 3'd0 || s_tlast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			index_q <= '0;
			pad_q   <= 1'b0;
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				// end of string: clear everything for the next one
				group_q <= '0;
				index_q <= '0;
				pad_q   <= 1'b0;
				count_q <= '0;
				drop_q  <= 1'b0;
			end else if (bad) begin
				drop_q <= 1'b1;
			end else if (!drop_q) begin
				pad_q   <= pad_n;
				count_q <= count_n;
				if (count_n >= limit) drop_q <= 1'b1;
				if (flush) begin
					group_q <= '0;
					index_q <= '0;
				end else begin
					group_q <= group_n;
					index_q <= index_q + 3'd1;
				end
			end
		end
	end

endmodule

>>> rtl/b32d_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module b32d_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b32d_pkg::job_t    push_job,
	input  logic              pop,
	output b32d_pkg::job_t    head_job,
	output logic              empty,
	output logic              full
);
	import b32d_pkg::*;

	job_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign head_job = entries_q[rd_ptr_q];
	assign empty    = fill_q == '0;
	assign full     = fill_q == (QPTR_W+1)'(QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> rtl/b32d_back.sv
// Back end: expand each job into results in the output register, one per cycle unless stalled.
`timescale 1ns / 1ps

module b32d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b32d_pkg::job_t    head_job,
	input  logic              empty,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // [7:0] out_byte, [8] run_last, [24:9] bytes_written
	output logic [1:0]        m_tuser,   // [0] byte_valid, [1] bad_char
	output logic              m_tlast    // string_done
);
	import b32d_pkg::*;

	logic [2:0]  slot_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        byte_valid_q, bad_q, run_last_q, done_q;
	logic [15:0] written_q;

	logic        load, has_bytes, final_slot;
	logic [2:0]  nres;
	logic [7:0]  byte_n;
	logic [15:0] written_n;

	always_comb begin
		has_bytes  = !head_job.bad && head_job.nbytes != 3'd0;
		nres       = has_bytes ? head_job.nbytes : 3'd1;
		final_slot = slot_q == nres - 3'd1;
		byte_n     = has_bytes ? head_job.bytes[slot_q] : 8'd0;
		written_n  = has_bytes ? head_job.count + 16'(slot_q) + 16'd1 : head_job.count;
		load       = !empty && (!valid_q || m_tready);
		pop        = load && final_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slot_q  <= '0;
		end else begin
			if (load)          valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
			if (load) slot_q <= final_slot ? 3'd0 : slot_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= byte_n;
			byte_valid_q <= has_bytes;
			bad_q        <= head_job.bad;
			run_last_q   <= final_slot;
			done_q       <= final_slot && head_job.last;
			written_q    <= written_n;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, written_q, run_last_q, byte_q};
	assign m_tuser  = {bad_q, byte_valid_q};
	assign m_tlast  = done_q;

endmodule

>>> rtl/base32_decoder.sv
// Top level of the streaming base32 decoder with its configuration register.
`timescale 1ns / 1ps

// Streaming base32 decoder.
// Input stream: one encoded character per transaction on s_tdata, s_tlast on
// the last character of a string. Output stream: one result per transaction,
// a decoded byte (m_tuser[0]), an illegal-character report (m_tuser[1]) or a
// bare end-of-string marker; m_tlast flags the final result of a string and
// m_tdata carries the byte, the per-character last flag and the running count.
// APB register 0 (address 0) holds output_limit, the most bytes per string;
// write it only while the decoder is idle.
// The front end decodes a character and updates the group state in the cycle
// it is accepted; the job then crosses a 4-entry queue and the back end emits
// its results one per cycle into the output register while the receiver is
// ready. A job passes the queue and then the output register before its first
// result. Input is taken at one character per cycle while the queue has room;
// the output side likewise runs at one result per cycle while not stalled.
// When the receiver stalls, the output register holds and the queue fills,
// then s_tready drops. Reset clears the string state and the queue and loads
// output_limit with 65535; no clearing pass is needed.
module base32_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_char
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] out_byte, [8] run_last, [24:9] bytes_written
	output logic [1:0]  m_tuser,   // [0] byte_valid, [1] bad_char
	output logic        m_tlast,   // string_done
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import b32d_pkg::*;

	logic [15:0] limit_q;
	logic        cfg_write;

	logic        push, pop, q_empty, q_full;
	job_t        push_job, head_job;

	// APB: zero wait states, register written in the access phase
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_write && paddr == REG_OUTPUT_LIMIT) begin
			limit_q <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (paddr)
			REG_OUTPUT_LIMIT: prdata = {16'd0, limit_q};
			default:          prdata = 32'd0;
		endcase
	end

	b32d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.limit    (limit_q),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	b32d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	b32d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> dv/base32_decoder_tb.sv
// Self-checking testbench for the streaming base32 decoder.
`timescale 1ns / 1ps

module base32_decoder_tb;
	import b32d_pkg::*;

	// One decoded result as the output stream carries it
	typedef struct packed {
		logic [7:0]  data;
		logic        valid;
		logic        bad;
		logic        run_last;
		logic        done;
		logic [15:0] count;
	} dec_result_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;    // [7:0] in_char
	logic        s_tlast  = 1'b0;  // end_of_string
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // [7:0] out_byte, [8] run_last, [24:9] bytes_written
	logic [1:0]  m_tuser;          // [0] byte_valid, [1] bad_char
	logic        m_tlast;          // string_done
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [0:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Decoder model state, mirrors the string state of the block
	logic [4:0]  grp [8]    = '{default: '0};
	logic [3:0]  fill       = '0;
	bit          pad_seen   = 1'b0;
	logic [15:0] emitted    = '0;
	bit          skipping   = 1'b0;
	logic [15:0] out_limit  = LIMIT_RESET;

	// Results predicted but not yet seen on the output stream
	dec_result_t due_results [$];
	int          mismatches = 0;

	// Traffic shaping knobs, in percent of cycles
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	logic        hold_req       = 1'b0;
	int          hold_left      = 0;

	base32_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	// Map a 5-bit symbol value to one of its alphabet characters
	function automatic logic [7:0] symbol_char(input logic [4:0] v, input bit lower);
		if (v < 5'd26)
			return (lower ? LOWER_FIRST : UPPER_FIRST) + 8'(v);
		return DIGIT_FIRST + 8'(v) - 8'd26;
	endfunction

	// Advance the decoder model by one accepted character and queue its results
	task automatic decode_char(input logic [7:0] ch, input bit last);
		dec_result_t outs [$];
		dec_result_t r;
		logic [4:0]  sym;
		logic [39:0] bits;
		bit          legal;
		legal = 1'b1;
		sym   = '0;
		if (!skipping) begin
			if (ch == PAD_CHAR) begin
				pad_seen = 1'b1;
			end else if (ch >= UPPER_FIRST && ch <= UPPER_LAST) begin
				sym = 5'(ch - UPPER_FIRST);
			end else if (ch >= LOWER_FIRST && ch <= LOWER_LAST) begin
				sym = 5'(ch - LOWER_FIRST);
			end else if (ch >= DIGIT_FIRST && ch <= DIGIT_LAST) begin
				sym = 5'(ch - DIGIT_FIRST + 8'd26);
			end else begin
				legal = 1'b0;
			end
			if (!legal) begin
				// illegal character: one error result, then drop the rest of the string
				r       = '0;
				r.bad   = 1'b1;
				r.count = emitted;
				outs.push_back(r);
				skipping = 1'b1;
			end else begin
				grp[fill[2:0]] = sym;
				fill = fill + 4'd1;
				if (fill == 4'd8 || pad_seen || last) begin
					// first symbol lands in the top bits of the 40-bit group
					bits = '0;
					for (int i = 0; i < 8; i++)
						if (i < fill)
							bits[39-5*i -: 5] = grp[i];
					grp  = '{default: '0};
					fill = '0;
					for (int i = 0; i < 5 && emitted < out_limit; i++) begin
						emitted = emitted + 16'd1;
						r       = '0;
						r.data  = bits[39-8*i -: 8];
						r.valid = 1'b1;
						r.count = emitted;
						outs.push_back(r);
					end
				end
				if (emitted >= out_limit)
					skipping = 1'b1;
			end
		end
		if (last && outs.size() == 0) begin
			// nothing else on the last character: a bare done marker
			r       = '0;
			r.count = emitted;
			outs.push_back(r);
		end
		if (last)
			outs[$].done = 1'b1;
		if (outs.size() != 0)
			outs[$].run_last = 1'b1;
		if (last) begin
			grp      = '{default: '0};
			fill     = '0;
			pad_seen = 1'b0;
			emitted  = '0;
			skipping = 1'b0;
		end
		foreach (outs[k])
			due_results.push_back(outs[k]);
	endtask

	// Offer one character, hold it until the transaction completes, then predict
	task automatic send_char(input logic [7:0] ch, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		decode_char(ch, last);
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_char(txt[i], i == txt.len() - 1);
	endtask

	// Mostly well-formed strings with random content, some padded, some with noise
	task automatic send_random_string(output int sent);
		int len;
		int pad;
		bit noisy;
		logic [7:0] ch;
		len   = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
		pad   = ($urandom_range(3) == 0) ? $urandom_range((len < 6) ? len : 6, 1) : 0;
		noisy = ($urandom_range(4) == 0);
		for (int i = 0; i < len; i++) begin
			if (i >= len - pad)
				ch = PAD_CHAR;
			else if (noisy && $urandom_range(99) < 15)
				ch = 8'($urandom_range(255));
			else
				ch = symbol_char(5'($urandom_range(31)), 1'($urandom_range(1)));
			send_char(ch, i == len - 1);
		end
		sent = len;
	endtask

	// Drop valid, drain every expected result, then let dropped items clear the pipe
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic write_output_limit(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_OUTPUT_LIMIT;
		pwdata  <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		out_limit = value;
	endtask

	// Receiver: random stalls, plus a long hold-off counted here on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left <= 200;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each output transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		dec_result_t got;
		dec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.data     = m_tdata[7:0];
			got.run_last = m_tdata[8];
			got.count    = m_tdata[24:9];
			got.valid    = m_tuser[0];
			got.bad      = m_tuser[1];
			got.done     = m_tlast;
			if (due_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected byte=%h valid=%b bad=%b last=%b done=%b cnt=%0d",
						$realtime, got.data, got.valid, got.bad, got.run_last, got.done,
						got.count);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					if (mismatches < 10) begin
						$display("%0t: mismatch exp byte=%h valid=%b bad=%b last=%b done=%b cnt=%0d",
							$realtime, want.data, want.valid, want.bad, want.run_last,
							want.done, want.count);
						$display("%0t:          got byte=%h valid=%b bad=%b last=%b done=%b cnt=%0d",
							$realtime, got.data, got.valid, got.bad, got.run_last,
							got.done, got.count);
					end
					mismatches++;
				end
			end
		end
	end

	// Alphabet edges, padding, illegal characters and the bare done marker
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_text("MZXW6YTBOI======");
		send_text("z7");
		// illegal byte, a dropped one, then a last character while dropping
		send_char(8'h00, 1'b0);
		send_char(8'hff, 1'b0);
		send_char(UPPER_FIRST, 1'b1);
		send_char(PAD_CHAR, 1'b1);
		send_char(8'h38, 1'b1);
		wait_quiet();
	endtask

	// Byte limit at zero and partway through a flush
	task automatic test_limit_edges();
		write_output_limit(16'd0);
		send_text("AB");
		wait_quiet();
		write_output_limit(16'd1);
		send_text("ABCDEFGH");
		wait_quiet();
		write_output_limit(16'd5);
		send_text("ABCDEFGHIJ");
		wait_quiet();
		write_output_limit(16'd6);
		send_text("ABCDEFGHIJKLMNOP");
		wait_quiet();
	endtask

	task automatic run_random_phase(input int n_items, input int send_pct, input int stall_pct,
			input logic [15:0] limit);
		int total;
		int sent;
		write_output_limit(limit);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		total = 0;
		while (total < n_items) begin
			send_random_string(sent);
			total += sent;
		end
		wait_quiet();
	endtask

	// Random phases with sender idles and receiver stalls, each with its own byte limit
	task automatic test_random_traffic();
		run_random_phase(45, 0, 0, LIMIT_RESET);
		run_random_phase(40, 70, 0, 16'($urandom_range(12)));
		run_random_phase(40, 0, 70, 16'd3);
		run_random_phase(40, 22, 22, 16'($urandom_range(40, 1)));
	endtask

	// Hold the receiver off long enough that the queue fills and input stalls
	task automatic test_backpressure();
		write_output_limit(LIMIT_RESET);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		for (int i = 0; i < 40; i++)
			send_char(symbol_char(5'($urandom_range(31)), 1'($urandom_range(1))), i == 39);
		wait_quiet();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limit_edges();
		test_random_traffic();
		test_backpressure();
		// anything still expected here never arrived
		mismatches += due_results.size();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> base32_decoder.f
rtl/b32d_pkg.sv
rtl/b32d_front.sv
rtl/b32d_queue.sv
rtl/b32d_back.sv
rtl/base32_decoder.sv
dv/base32_decoder_tb.sv
